>>> design/bsac_pkg.sv
// ----------------------------------------------------------------------------
// bsac_pkg
// Shared types and constants for the bounded-step array counter.
// ----------------------------------------------------------------------------
package bsac_pkg;

	localparam int ENTRY_W = 8;
	localparam int LIMIT_W = 8;
	localparam int COUNT_W = 30;
	localparam int OUT_TDATA_W = 32;

	localparam logic [COUNT_W-1:0] COUNT_MOD = 30'd1000000007;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load;      // capture a new word and clear the total
		logic first;     // the word opens a new array (valid with load)
		logic sweep;     // row sweep step at the current index
		logic out_load;  // copy the total into the output register
	} dp_cmd_t;

endpackage

>>> design/bsac_ram.sv
// ----------------------------------------------------------------------------
// bsac_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module bsac_ram #(
	parameter int WIDTH = 30,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

>>> design/bsac_datapath.sv
// ----------------------------------------------------------------------------
// bsac_datapath
// Row memory, three-entry window, neighbour sum pipeline, running total and
// result register.
// ----------------------------------------------------------------------------
module bsac_datapath #(
	parameter int MAX_VALUE = 128,
	parameter int CW = $clog2(MAX_VALUE + 2)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  bsac_pkg::dp_cmd_t                cmd,
	input  logic [CW-1:0]                    idx,
	input  logic [bsac_pkg::ENTRY_W-1:0]     entry_value,
	input  logic                             cfg_wr_en,
	input  logic [bsac_pkg::LIMIT_W-1:0]     cfg_wr_data,
	output logic [bsac_pkg::COUNT_W-1:0]     array_count
);
	import bsac_pkg::*;

	localparam int AW = $clog2(MAX_VALUE);
	localparam int WW = (CW + 1 > ENTRY_W + 1) ? CW + 1 : ENTRY_W + 1;
	localparam logic [WW-1:0] N_W = WW'(MAX_VALUE);

	function automatic logic [COUNT_W-1:0] reduce3(input logic [COUNT_W+1:0] s);
		logic [COUNT_W+1:0] p1;
		logic [COUNT_W+1:0] p2;
		p1 = {2'b00, COUNT_MOD};
		p2 = {1'b0, COUNT_MOD, 1'b0};
		if (s >= p2) begin
			reduce3 = COUNT_W'(s - p2);
		end else if (s >= p1) begin
			reduce3 = COUNT_W'(s - p1);
		end else begin
			reduce3 = COUNT_W'(s);
		end
	endfunction

	function automatic logic [COUNT_W-1:0] mod_add(input logic [COUNT_W-1:0] a,
			input logic [COUNT_W-1:0] b);
		logic [COUNT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= {1'b0, COUNT_MOD}) begin
			mod_add = COUNT_W'(s - {1'b0, COUNT_MOD});
		end else begin
			mod_add = COUNT_W'(s);
		end
	endfunction

	logic [LIMIT_W-1:0] limit_q;
	logic [WW-1:0]      v_q;
	logic [WW-1:0]      m_q;
	logic               first_q;
	logic [COUNT_W-1:0] prev_q;
	logic [COUNT_W-1:0] cur_q;
	logic [COUNT_W+1:0] sum_s2;
	logic [WW-1:0]      k_s2;
	logic               vld_s2;
	logic [COUNT_W-1:0] acc_q;
	logic [COUNT_W-1:0] out_q;

	logic [WW-1:0]      idx_w;
	logic [WW-1:0]      lim_w;
	logic [WW-1:0]      k_s1;
	logic               go_s1;
	logic               rd_en;
	logic [COUNT_W-1:0] rd_data;
	logic [COUNT_W+1:0] sum_s1;
	logic [COUNT_W-1:0] red_s2;
	logic               hit_s2;
	logic               in_s2;
	logic [COUNT_W-1:0] new_s2;

	assign idx_w = WW'(idx);
	assign lim_w = WW'(limit_q);
	assign k_s1  = idx_w - WW'(2);
	assign go_s1 = cmd.sweep && (idx_w >= WW'(2));
	assign rd_en = cmd.sweep && (idx_w < N_W);

	bsac_ram #(
		.WIDTH(COUNT_W),
		.DEPTH(MAX_VALUE)
	) u_row (
		.clk    (clk),
		.wr_en  (vld_s2),
		.wr_addr(k_s2[AW-1:0]),
		.wr_data(new_s2),
		.rd_en  (rd_en),
		.rd_addr(idx[AW-1:0]),
		.rd_data(rd_data)
	);

	// neighbour sum of the entry at k: cur_q is old[k], prev_q old[k-1], rd_data old[k+1]
	always_comb begin
		sum_s1 = '0;
		if (k_s1 < m_q) begin
			sum_s1 = {2'b00, cur_q};
			if (k_s1 != '0) begin
				sum_s1 = sum_s1 + {2'b00, prev_q};
			end
			if (k_s1 + WW'(1) < m_q) begin
				sum_s1 = sum_s1 + {2'b00, rd_data};
			end
		end
	end

	always_comb begin
		red_s2 = reduce3(sum_s2);
		hit_s2 = (k_s2 + WW'(1) == v_q);
		in_s2  = (k_s2 < m_q);
		if (first_q) begin
			if (v_q == '0) begin
				new_s2 = in_s2 ? COUNT_W'(1) : '0;
			end else begin
				new_s2 = (hit_s2 && in_s2) ? COUNT_W'(1) : '0;
			end
		end else if (v_q == '0 || hit_s2) begin
			new_s2 = red_s2;
		end else begin
			new_s2 = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_W'(1);
			vld_s2  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				limit_q <= cfg_wr_data;
			end
			vld_s2 <= go_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			v_q     <= WW'(entry_value);
			m_q     <= (lim_w > N_W) ? N_W : lim_w;
			first_q <= cmd.first;
		end
		if (cmd.sweep) begin
			prev_q <= cur_q;
			cur_q  <= rd_data;
		end
		sum_s2 <= sum_s1;
		k_s2   <= k_s1;
		if (cmd.load) begin
			acc_q <= '0;
		end else if (vld_s2) begin
			acc_q <= mod_add(acc_q, new_s2);
		end
		if (cmd.out_load) begin
			out_q <= acc_q;
		end
	end

	assign array_count = out_q;

endmodule

>>> design/bsac_ctrl.sv
// ----------------------------------------------------------------------------
// bsac_ctrl
// Controller: takes a word, runs the row sweep, drains the pipeline and
// hands the total to the output register on the last word of an array.
// ----------------------------------------------------------------------------
module bsac_ctrl #(
	parameter int MAX_VALUE = 128,
	parameter int CW = $clog2(MAX_VALUE + 2)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_last,
	output logic              in_ready,
	input  logic              out_ready,
	output logic              out_valid,
	output bsac_pkg::dp_cmd_t cmd,
	output logic [CW-1:0]     idx
);
	import bsac_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SWEEP = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_WAIT  = 2'd3;

	localparam logic [CW-1:0] IDX_END = CW'(MAX_VALUE + 1);

	logic [1:0]    state_q;
	logic [CW-1:0] idx_q;
	logic          last_q;
	logic          first_q;
	logic          out_valid_q;
	logic          slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign idx       = idx_q;

	always_comb begin
		cmd          = '0;
		cmd.load     = (state_q == ST_IDLE) && in_valid;
		cmd.first    = first_q;
		cmd.sweep    = (state_q == ST_SWEEP);
		cmd.out_load = (state_q == ST_WAIT) && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			last_q      <= 1'b0;
			first_q     <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			// load a new result, or drop the one just taken
			if ((state_q == ST_WAIT) && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						last_q  <= in_last;
						idx_q   <= '0;
						state_q <= ST_SWEEP;
					end
				end
				ST_SWEEP: begin
					if (idx_q == IDX_END) begin
						state_q <= ST_DRAIN;
					end else begin
						idx_q <= idx_q + CW'(1);
					end
				end
				ST_DRAIN: begin
					// the last row entry is written in this cycle
					first_q <= last_q;
					state_q <= last_q ? ST_WAIT : ST_IDLE;
				end
				ST_WAIT: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> design/bounded_step_array_counter_core.sv
// Each word is taken in idle; the controller then sweeps the row memory, drains the
// pipeline and, for a last word, waits to load the output register before it takes another;
// the sweep goes over the row memory one entry per cycle through one read port.
// A result left waiting on the output holds back a later last word after its sweep.
// Reset: arst_n clears control, sets value_limit to 1 and opens a new array;
// the row memory is not cleared, the first word of each array rewrites it.
// ----------------------------------------------------------------------------
// bounded_step_array_counter_core
// Counts arrays with values 1..m and neighbour steps of at most one that
// match the given entries, modulo 1000000007.
// ----------------------------------------------------------------------------
module bounded_step_array_counter_core #(
	parameter int MAX_VALUE = 128
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [bsac_pkg::LIMIT_W-1:0]  cfg_wr_data,    // value_limit
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [bsac_pkg::ENTRY_W-1:0]  s_axis_tdata,   // [7:0] entry_value
	input  logic                          s_axis_tlast,   // last_entry
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [bsac_pkg::OUT_TDATA_W-1:0] m_axis_tdata // [29:0] array_count
);
	import bsac_pkg::*;

	localparam int CW = $clog2(MAX_VALUE + 2);

	dp_cmd_t            cmd;
	logic [CW-1:0]      idx;
	logic [COUNT_W-1:0] array_count;

	bsac_ctrl #(
		.MAX_VALUE(MAX_VALUE),
		.CW       (CW)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_last  (s_axis_tlast),
		.in_ready (s_axis_tready),
		.out_ready(m_axis_tready),
		.out_valid(m_axis_tvalid),
		.cmd      (cmd),
		.idx      (idx)
	);

	bsac_datapath #(
		.MAX_VALUE(MAX_VALUE),
		.CW       (CW)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.idx        (idx),
		.entry_value(s_axis_tdata),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.array_count(array_count)
	);

	assign m_axis_tdata = {{(OUT_TDATA_W - COUNT_W){1'b0}}, array_count};

`ifndef SYNTH
	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[COUNT_W-1:0] < COUNT_MOD))
		else $error("result not reduced below the modulus");

	a_busy_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sweep |-> !s_axis_tready)
		else $error("input ready during a row sweep");

	a_taken_then_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> (cmd.sweep && idx == '0))
		else $error("accepted word did not start a sweep");
`endif

endmodule

>>> sim/tb_bounded_step_array_counter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bounded_step_array_counter_core
// Streams array entries into the counter and checks every array count it
// returns against a cycle-free model of the count row kept in the bench.
// A directed set covers the limit extremes, free and fixed entries, values
// above the limit and a limit change inside an array; random phases of
// mostly well-formed arrays follow, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module tb_bounded_step_array_counter_core;

	import bsac_pkg::*;

	localparam int MAX_VALUE = 128;
	localparam int RANDOM_WORDS = 1500;
	localparam int SETTLE_CYCLES = MAX_VALUE + 12;
	localparam logic [ENTRY_W-1:0] FREE_ENTRY = '0;

	typedef struct {
		logic [ENTRY_W-1:0] entry;
		bit                 last;
	} entry_word_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_wr_en = 1'b0;
	logic [LIMIT_W-1:0]     cfg_wr_data = '0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [ENTRY_W-1:0]     s_axis_tdata = '0;
	logic                   s_axis_tlast = 1'b0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	// bench copy of the block state
	logic [COUNT_W-1:0] count_row [MAX_VALUE];
	bit                 at_first_entry = 1'b1;
	logic [LIMIT_W-1:0] limit_setting = 8'd1;

	entry_word_t        pending_words [$];
	logic [COUNT_W-1:0] expected_counts [$];
	int unsigned        error_count = 0;

	int unsigned send_idle = 0;
	int unsigned recv_stall = 0;
	bit          send_quiet = 1'b0;
	bit          recv_quiet = 1'b0;
	entry_word_t next_word;
	logic [COUNT_W-1:0] want_count;

	bounded_step_array_counter_core #(.MAX_VALUE(MAX_VALUE)) u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),   // [7:0] entry_value
		.s_axis_tlast  (s_axis_tlast),   // last_entry
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)    // [29:0] array_count
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int unsigned draw_idle();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 4);
		return $urandom_range(5, 250);
	endfunction

	function automatic int unsigned active_limit();
		return (limit_setting > MAX_VALUE) ? MAX_VALUE : limit_setting;
	endfunction

	// count at idx plus its neighbours, all inside 0..lim-1
	function automatic logic [COUNT_W-1:0] neighbour_total(int unsigned idx, int unsigned lim);
		longint unsigned s;
		if (idx >= lim)
			return '0;
		s = count_row[idx];
		if (idx > 0)
			s += count_row[idx-1];
		if (idx + 1 < lim)
			s += count_row[idx+1];
		return COUNT_W'(s % COUNT_MOD);
	endfunction

	task automatic step_counts(input logic [ENTRY_W-1:0] entry, input bit last_word);
		logic [COUNT_W-1:0] next_row [MAX_VALUE];
		logic [COUNT_W-1:0] keep;
		longint unsigned    total;
		int unsigned        lim;
		lim = active_limit();
		if (at_first_entry) begin
			for (int j = 0; j < MAX_VALUE; j++)
				next_row[j] = (entry == FREE_ENTRY && j < lim) ? COUNT_W'(1) : '0;
			if (entry != FREE_ENTRY && entry <= lim)
				next_row[entry-1] = COUNT_W'(1);
		end else if (entry == FREE_ENTRY) begin
			for (int j = 0; j < MAX_VALUE; j++)
				next_row[j] = neighbour_total(j, lim);
		end else begin
			keep = (entry <= lim) ? neighbour_total(entry - 1, lim) : '0;
			for (int j = 0; j < MAX_VALUE; j++)
				next_row[j] = '0;
			if (entry <= lim)
				next_row[entry-1] = keep;
		end
		count_row = next_row;
		at_first_entry = 1'b0;
		if (last_word) begin
			total = 0;
			if (entry == FREE_ENTRY) begin
				for (int j = 0; j < lim; j++)
					total += count_row[j];
			end else if (entry <= lim) begin
				total = count_row[entry-1];
			end
			expected_counts = {expected_counts, COUNT_W'(total % COUNT_MOD)};
			at_first_entry = 1'b1;
		end
	endtask

	// sender: hold each word until taken, then a random gap
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				step_counts(s_axis_tdata, s_axis_tlast);
			if (!s_axis_tvalid || s_axis_tready) begin
				if (send_idle > 0) begin
					s_axis_tvalid <= 1'b0;
					send_idle--;
				end else if (pending_words.size() > 0) begin
					next_word = pending_words.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= next_word.entry;
					s_axis_tlast <= next_word.last;
					if ($urandom_range(0, 49) == 0)
						send_quiet = !send_quiet;
					send_idle = send_quiet ? 0 : draw_idle();
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver: check each word taken, stall at random
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_counts.size() == 0) begin
					$error("array_count: expected none, actual %0d", m_axis_tdata[COUNT_W-1:0]);
					error_count++;
				end else begin
					want_count = expected_counts.pop_front();
					if (m_axis_tdata[COUNT_W-1:0] !== want_count) begin
						$error("array_count: expected %0d, actual %0d",
							want_count, m_axis_tdata[COUNT_W-1:0]);
						error_count++;
					end
				end
			end
			if (recv_stall > 0) begin
				m_axis_tready <= 1'b0;
				recv_stall--;
			end else begin
				m_axis_tready <= 1'b1;
				if ($urandom_range(0, 99) == 0)
					recv_quiet = !recv_quiet;
				if (!recv_quiet && $urandom_range(0, 7) == 0)
					recv_stall = draw_idle();
			end
		end
	end

	task automatic queue_word(input logic [ENTRY_W-1:0] entry, input bit last_word);
		entry_word_t w;
		w.entry = entry;
		w.last = last_word;
		pending_words = {pending_words, w};
	endtask

	// wait until every word is taken and every count is back, then let the sweep finish
	task automatic drain();
		while (pending_words.size() > 0 || s_axis_tvalid || expected_counts.size() > 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(input logic [LIMIT_W-1:0] lim);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= lim;
		limit_setting = lim;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	function automatic logic [LIMIT_W-1:0] pick_limit();
		int unsigned r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return '0;
		if (r == 1)
			return LIMIT_W'($urandom_range(MAX_VALUE + 1, 255));
		if (r < 6)
			return LIMIT_W'($urandom_range(1, 3));
		if (r < 10)
			return LIMIT_W'($urandom_range(4, 16));
		if (r < 16)
			return LIMIT_W'($urandom_range(17, MAX_VALUE - 1));
		return LIMIT_W'(MAX_VALUE);
	endfunction

	// one array: a bounded walk with some entries revealed, or plain noise
	task automatic queue_array(input int unsigned len, input bit close, inout int unsigned n);
		int unsigned lim;
		int unsigned reveal_pct;
		int          walk;
		bit          noisy;
		logic [ENTRY_W-1:0] e;
		lim = active_limit();
		noisy = (lim == 0) || ($urandom_range(0, 6) == 0);
		reveal_pct = $urandom_range(0, 100);
		walk = (lim == 0) ? 0 : $urandom_range(1, lim);
		for (int i = 0; i < len; i++) begin
			if (noisy) begin
				e = $urandom_range(0, 1) ? FREE_ENTRY : ENTRY_W'($urandom_range(1, 255));
			end else begin
				walk += $urandom_range(0, 2) - 1;
				if (walk < 1)
					walk = 1;
				if (walk > lim)
					walk = lim;
				e = ($urandom_range(1, 100) <= reveal_pct) ? ENTRY_W'(walk) : FREE_ENTRY;
				// break the odd walk
				if ($urandom_range(0, 39) == 0)
					e = ENTRY_W'($urandom_range(0, 255));
			end
			queue_word(e, close && (i == len - 1));
			n++;
		end
	endtask

	initial begin
		int unsigned random_words;
		int unsigned phase_words;
		int unsigned n;
		int unsigned len;
		int unsigned r;

		random_words = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// limit left at its reset value of one
		queue_word(8'd0, 1);
		queue_word(8'd1, 1);
		queue_word(8'd2, 1);
		drain();

		write_limit(LIMIT_W'(MAX_VALUE));
		queue_word(8'd0, 0);
		queue_word(8'd0, 0);
		queue_word(8'd0, 1);
		queue_word(8'd128, 0);
		queue_word(8'd0, 1);
		queue_word(8'd255, 1);
		queue_word(8'd1, 0);
		queue_word(8'd2, 0);
		queue_word(8'd1, 1);
		queue_word(8'd5, 0);
		queue_word(8'd7, 1);
		queue_word(8'd0, 0);
		queue_word(8'd128, 1);
		queue_word(8'd64, 1);
		// leave this array open across the limit change
		queue_word(8'd0, 0);
		drain();

		write_limit(8'd3);
		queue_word(8'd0, 1);
		drain();

		write_limit(8'd0);
		queue_word(8'd0, 1);
		queue_word(8'd1, 0);
		queue_word(8'd0, 1);
		drain();

		write_limit(8'd255);
		queue_word(8'd0, 0);
		queue_word(8'd0, 1);
		queue_word(8'd129, 1);
		drain();

		while (random_words < RANDOM_WORDS) begin
			write_limit(pick_limit());
			phase_words = $urandom_range(40, 200);
			n = 0;
			while (n < phase_words) begin
				r = $urandom_range(0, 99);
				if (r < 80)
					len = $urandom_range(1, 8);
				else if (r < 95)
					len = $urandom_range(9, 25);
				else
					len = $urandom_range(26, 60);
				queue_array(len, 1'b1, n);
			end
			// sometimes carry an open array into the next limit
			if ($urandom_range(0, 3) == 0)
				queue_array($urandom_range(1, 5), 1'b0, n);
			random_words += n;
			drain();
		end

		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#80_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
